// ===== hw/rtl/agcn_pkg.sv =====
// ----------------------------------------------------------------------------
// agcn_pkg
// Shared widths, constants, register codes and the controller/datapath
// command and status types of the AGC envelope normalizer.
// ----------------------------------------------------------------------------
package agcn_pkg;

	// sample and coefficient formats
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int ENV_W    = SAMPLE_W - 1;
	localparam int MAG_W    = SAMPLE_W;

	// shared multiplier
	localparam int MA_W   = (COEF_W + 1 > SAMPLE_W) ? COEF_W + 1 : SAMPLE_W;
	localparam int PROD_W = MA_W + SAMPLE_W;
	localparam int ER_W   = PROD_W - COEF_W;

	// square root and divider
	localparam int SQ_W     = 2 * SAMPLE_W;
	localparam int SQ_ITER  = SAMPLE_W;
	localparam int DVD_W    = 2 * SAMPLE_W;
	localparam int D5_W     = ENV_W + 3;
	localparam int DEN_W    = ENV_W + 4;
	localparam int QUO_W    = SAMPLE_W + 2;
	localparam int DIV_ITER = QUO_W;
	localparam int CNT_W    = $clog2(DIV_ITER);

	// config port
	localparam int APB_DW    = 32;
	localparam int PADDR_W   = 5;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_ATTACK  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_RELEASE = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_FLOOR   = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_AM_MODE = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_IQ_SWAP = REG_IDX_W'(4);

	// reset values
	localparam logic [COEF_W-1:0] ATTACK_RESET  = COEF_W'(64910);
	localparam logic [COEF_W-1:0] RELEASE_RESET = COEF_W'(65534);
	localparam logic [ENV_W-1:0]  FLOOR_RESET   = ENV_W'(33);

	// fixed-point limits
	localparam logic [ENV_W-1:0]    ENV_MAX   = {ENV_W{1'b1}};
	localparam logic [COEF_W:0]     COEF_ONE  = {1'b1, {COEF_W{1'b0}}};
	localparam logic [PROD_W-1:0]   ROUND_HALF = PROD_W'(1) << (COEF_W - 1);
	localparam logic [QUO_W-1:0]    QUO_HALF  = QUO_W'(1) << (SAMPLE_W - 1);
	localparam logic [QUO_W-1:0]    QUO_MAX   = QUO_HALF - QUO_W'(1);
	localparam logic [SAMPLE_W-1:0] SAT_POS   = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] SAT_NEG   = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// multiplier operand selection
	typedef logic [1:0] mul_sel_t;
	localparam mul_sel_t MUL_C    = 2'd0;
	localparam mul_sel_t MUL_CINV = 2'd1;
	localparam mul_sel_t MUL_I    = 2'd2;
	localparam mul_sel_t MUL_Q    = 2'd3;

	typedef struct packed {
		logic [COEF_W-1:0] attack_coef;
		logic [COEF_W-1:0] release_coef;
		logic [ENV_W-1:0]  envelope_floor;
		logic              am_mode;
		logic              iq_swap;
	} cfg_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_load;
		logic     sq_init;
		logic     sq_step;
		logic     sq_fin;
		logic     env_upd;
		logic     div_prep;
		logic     div_init;
		logic     div_step;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic out_blocked;
	} sts_t;

endpackage

// ===== hw/rtl/agcn_cfg.sv =====
// ----------------------------------------------------------------------------
// agcn_cfg
// APB register file: attack/release coefficients, envelope floor, AM mode
// and I/Q swap.
// ----------------------------------------------------------------------------
module agcn_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [agcn_pkg::PADDR_W-1:0]  paddr,
	input  logic [agcn_pkg::APB_DW-1:0]   pwdata,
	output logic [agcn_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	output agcn_pkg::cfg_t                cfg
);

	logic                            wr_en;
	logic [agcn_pkg::REG_IDX_W-1:0]  reg_idx;
	agcn_pkg::cfg_t                  cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[agcn_pkg::PADDR_W-1:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_coef    <= agcn_pkg::ATTACK_RESET;
			cfg_q.release_coef   <= agcn_pkg::RELEASE_RESET;
			cfg_q.envelope_floor <= agcn_pkg::FLOOR_RESET;
			cfg_q.am_mode        <= 1'b0;
			cfg_q.iq_swap        <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				agcn_pkg::REG_ATTACK: begin
					cfg_q.attack_coef <= pwdata[agcn_pkg::COEF_W-1:0];
				end
				agcn_pkg::REG_RELEASE: begin
					cfg_q.release_coef <= pwdata[agcn_pkg::COEF_W-1:0];
				end
				agcn_pkg::REG_FLOOR: begin
					cfg_q.envelope_floor <= pwdata[agcn_pkg::ENV_W-1:0];
				end
				agcn_pkg::REG_AM_MODE: begin
					cfg_q.am_mode <= pwdata[0];
				end
				agcn_pkg::REG_IQ_SWAP: begin
					cfg_q.iq_swap <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			agcn_pkg::REG_ATTACK:  prdata = agcn_pkg::APB_DW'(cfg_q.attack_coef);
			agcn_pkg::REG_RELEASE: prdata = agcn_pkg::APB_DW'(cfg_q.release_coef);
			agcn_pkg::REG_FLOOR:   prdata = agcn_pkg::APB_DW'(cfg_q.envelope_floor);
			agcn_pkg::REG_AM_MODE: prdata = agcn_pkg::APB_DW'(cfg_q.am_mode);
			agcn_pkg::REG_IQ_SWAP: prdata = agcn_pkg::APB_DW'(cfg_q.iq_swap);
			default:               prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/agcn_ctrl.sv =====
// ----------------------------------------------------------------------------
// agcn_ctrl
// Sequencer for one sample: optional squares and square root, envelope
// update through the shared multiplier, restoring divide, output load.
// ----------------------------------------------------------------------------
module agcn_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           am_mode,
	input  agcn_pkg::sts_t sts,
	output logic           in_stall,
	output agcn_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_MUL_I    = 4'd1;
	localparam logic [3:0] S_MUL_Q    = 4'd2;
	localparam logic [3:0] S_SQ_INIT  = 4'd3;
	localparam logic [3:0] S_SQ_STEP  = 4'd4;
	localparam logic [3:0] S_SQ_FIN   = 4'd5;
	localparam logic [3:0] S_ENV_C    = 4'd6;
	localparam logic [3:0] S_ENV_V    = 4'd7;
	localparam logic [3:0] S_ENV_UPD  = 4'd8;
	localparam logic [3:0] S_DIV_PREP = 4'd9;
	localparam logic [3:0] S_DIV_INIT = 4'd10;
	localparam logic [3:0] S_DIV_STEP = 4'd11;
	localparam logic [3:0] S_OUT      = 4'd12;

	localparam logic [agcn_pkg::CNT_W-1:0] SQ_LAST  = agcn_pkg::CNT_W'(agcn_pkg::SQ_ITER - 1);
	localparam logic [agcn_pkg::CNT_W-1:0] DIV_LAST = agcn_pkg::CNT_W'(agcn_pkg::DIV_ITER - 1);

	logic [3:0]                   state_q, state_d;
	logic [agcn_pkg::CNT_W-1:0]   cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = am_mode ? S_MUL_I : S_ENV_C;
				end
			end
			S_MUL_I: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = agcn_pkg::MUL_I;
				state_d     = S_MUL_Q;
			end
			S_MUL_Q: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = agcn_pkg::MUL_Q;
				cmd.acc_load = 1'b1;
				state_d      = S_SQ_INIT;
			end
			S_SQ_INIT: begin
				cmd.sq_init = 1'b1;
				cnt_d       = '0;
				state_d     = S_SQ_STEP;
			end
			S_SQ_STEP: begin
				cmd.sq_step = 1'b1;
				cnt_d       = cnt_q + 1'b1;
				if (cnt_q == SQ_LAST) begin
					state_d = S_SQ_FIN;
				end
			end
			S_SQ_FIN: begin
				cmd.sq_fin = 1'b1;
				state_d    = S_ENV_C;
			end
			S_ENV_C: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = agcn_pkg::MUL_C;
				state_d     = S_ENV_V;
			end
			S_ENV_V: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = agcn_pkg::MUL_CINV;
				cmd.acc_load = 1'b1;
				state_d      = S_ENV_UPD;
			end
			S_ENV_UPD: begin
				cmd.env_upd = 1'b1;
				state_d     = S_DIV_PREP;
			end
			S_DIV_PREP: begin
				cmd.div_prep = 1'b1;
				state_d      = S_DIV_INIT;
			end
			S_DIV_INIT: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = S_DIV_STEP;
			end
			S_DIV_STEP: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!sts.out_blocked) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/agcn_dp.sv =====
// ----------------------------------------------------------------------------
// agcn_dp
// Datapath: I/Q swap and magnitudes, one shared multiplier with an
// accumulator, a one-bit-per-cycle square root, a one-bit-per-cycle
// restoring divider, the envelope register and the output register.
// ----------------------------------------------------------------------------
module agcn_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  agcn_pkg::cfg_t                      cfg,
	input  agcn_pkg::cmd_t                      cmd,
	input  logic signed [agcn_pkg::SAMPLE_W-1:0] sample_i,
	input  logic signed [agcn_pkg::SAMPLE_W-1:0] sample_q,
	input  logic                                out_stall,
	output agcn_pkg::sts_t                      sts,
	output logic                                out_valid,
	output logic signed [agcn_pkg::SAMPLE_W-1:0] audio_out,
	output logic [agcn_pkg::ENV_W-1:0]          envelope_now,
	output logic                                clipped
);

	// input stage
	logic [agcn_pkg::SAMPLE_W-1:0] ri, rq, ai_n, aq_n;
	logic [agcn_pkg::MAG_W-1:0]    ai_q, aq_q;
	logic                          neg_q;

	// multiplier and accumulator
	logic                          v_gt;
	logic [agcn_pkg::COEF_W-1:0]   coef;
	logic [agcn_pkg::COEF_W:0]     coef_inv;
	logic [agcn_pkg::MA_W-1:0]     mul_a;
	logic [agcn_pkg::SAMPLE_W-1:0] mul_b;
	logic [agcn_pkg::PROD_W-1:0]   prod_q, acc_q, sum;

	// envelope
	logic [agcn_pkg::ENV_W-1:0]    env_q, floor_eff, env_new;
	logic [agcn_pkg::PROD_W-1:0]   env_tot;
	logic [agcn_pkg::ER_W-1:0]     env_raw, env_lo;

	// square root
	logic [agcn_pkg::SQ_W-1:0]     s_q, r_q, bit_q, sq_t, sq_round;
	logic                          sq_ge;
	logic [agcn_pkg::MAG_W-1:0]    num_q, num_sel;
	logic                          clip_q;

	// divider
	logic [agcn_pkg::D5_W-1:0]     d5;
	logic [agcn_pkg::DVD_W-1:0]    dvd_n, dvd_q;
	logic [agcn_pkg::DEN_W-1:0]    den_q, rem_q;
	logic [agcn_pkg::QUO_W-1:0]    lo_q, quo_q;
	logic                          ovf_q;
	logic [agcn_pkg::DEN_W:0]      div_t, div_diff;
	logic                          div_ge;

	// output stage
	logic [agcn_pkg::SAMPLE_W-1:0] q_lo, res_n;
	logic                          sat_n;
	logic                          out_valid_q;

	// swap and magnitudes
	assign ri   = cfg.iq_swap ? sample_q : sample_i;
	assign rq   = cfg.iq_swap ? sample_i : sample_q;
	assign ai_n = ri[agcn_pkg::SAMPLE_W-1] ? (~ri) + agcn_pkg::SAMPLE_W'(1) : ri;
	assign aq_n = rq[agcn_pkg::SAMPLE_W-1] ? (~rq) + agcn_pkg::SAMPLE_W'(1) : rq;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ai_q   <= ai_n;
			aq_q   <= aq_n;
			neg_q  <= ri[agcn_pkg::SAMPLE_W-1] & ~cfg.am_mode;
		end
	end

	// coefficient choice: attack on a rising signal
	assign v_gt     = ai_q > agcn_pkg::MAG_W'(env_q);
	assign coef     = v_gt ? cfg.attack_coef : cfg.release_coef;
	assign coef_inv = agcn_pkg::COEF_ONE - {1'b0, coef};

	// multiplier operands
	always_comb begin
		case (cmd.mul_sel)
			agcn_pkg::MUL_C: begin
				mul_a = agcn_pkg::MA_W'(coef);
				mul_b = agcn_pkg::SAMPLE_W'(env_q);
			end
			agcn_pkg::MUL_CINV: begin
				mul_a = agcn_pkg::MA_W'(coef_inv);
				mul_b = ai_q;
			end
			agcn_pkg::MUL_I: begin
				mul_a = agcn_pkg::MA_W'(ai_q);
				mul_b = ai_q;
			end
			agcn_pkg::MUL_Q: begin
				mul_a = agcn_pkg::MA_W'(aq_q);
				mul_b = aq_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign sum = acc_q + prod_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= agcn_pkg::PROD_W'(mul_a) * agcn_pkg::PROD_W'(mul_b);
		end
		if (cmd.acc_load) begin
			acc_q <= prod_q;
		end
	end

	// envelope update, rounded, then floor and ceiling
	assign floor_eff = (cfg.envelope_floor == '0) ? agcn_pkg::ENV_W'(1) : cfg.envelope_floor;
	assign env_tot   = sum + agcn_pkg::ROUND_HALF;
	assign env_raw   = env_tot[agcn_pkg::PROD_W-1:agcn_pkg::COEF_W];
	assign env_lo    = (env_raw < agcn_pkg::ER_W'(floor_eff)) ?
		agcn_pkg::ER_W'(floor_eff) : env_raw;
	assign env_new   = (env_lo > agcn_pkg::ER_W'(agcn_pkg::ENV_MAX)) ?
		agcn_pkg::ENV_MAX : env_lo[agcn_pkg::ENV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= agcn_pkg::FLOOR_RESET;
		end else if (cmd.env_upd) begin
			env_q <= env_new;
		end
	end

	// square root, one result bit per cycle
	assign sq_t     = r_q + bit_q;
	assign sq_ge    = s_q >= sq_t;
	assign sq_round = (s_q > r_q) ? r_q + agcn_pkg::SQ_W'(1) : r_q;

	always_ff @(posedge clk) begin
		if (cmd.sq_init) begin
			s_q   <= sum[agcn_pkg::SQ_W-1:0];
			r_q   <= '0;
			bit_q <= agcn_pkg::SQ_W'(1) << (agcn_pkg::SQ_W - 2);
		end else if (cmd.sq_step) begin
			bit_q <= bit_q >> 2;
			if (sq_ge) begin
				s_q <= s_q - sq_t;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

	// magnitude clamp and clip flag
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			clip_q <= 1'b0;
		end else if (cmd.sq_fin) begin
			if (sq_round > agcn_pkg::SQ_W'(agcn_pkg::ENV_MAX)) begin
				num_q  <= agcn_pkg::MAG_W'(agcn_pkg::ENV_MAX);
				clip_q <= 1'b1;
			end else begin
				num_q <= sq_round[agcn_pkg::MAG_W-1:0];
			end
		end
	end

	// divider operands: (num << SAMPLE_W) + 5e over 10e
	assign num_sel = cfg.am_mode ? num_q : ai_q;
	assign d5      = agcn_pkg::D5_W'({env_q, 2'b00}) + agcn_pkg::D5_W'(env_q);
	assign dvd_n   = {num_sel, {agcn_pkg::SAMPLE_W{1'b0}}} + agcn_pkg::DVD_W'(d5);

	// restoring divide step
	assign div_t    = {rem_q, lo_q[agcn_pkg::QUO_W-1]};
	assign div_diff = div_t - {1'b0, den_q};
	assign div_ge   = div_t >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.div_prep) begin
			den_q <= {d5, 1'b0};
			dvd_q <= dvd_n;
		end else if (cmd.div_init) begin
			ovf_q <= agcn_pkg::DEN_W'(dvd_q[agcn_pkg::DVD_W-1:agcn_pkg::QUO_W]) >= den_q;
			rem_q <= agcn_pkg::DEN_W'(dvd_q[agcn_pkg::DVD_W-1:agcn_pkg::QUO_W]);
			lo_q  <= dvd_q[agcn_pkg::QUO_W-1:0];
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? div_diff[agcn_pkg::DEN_W-1:0] : div_t[agcn_pkg::DEN_W-1:0];
			lo_q  <= lo_q << 1;
			quo_q <= {quo_q[agcn_pkg::QUO_W-2:0], div_ge};
		end
	end

	// sign and saturation
	assign q_lo = quo_q[agcn_pkg::SAMPLE_W-1:0];

	always_comb begin
		if (neg_q) begin
			sat_n = ovf_q | (quo_q > agcn_pkg::QUO_HALF);
			res_n = sat_n ? agcn_pkg::SAT_NEG : (~q_lo) + agcn_pkg::SAMPLE_W'(1);
		end else begin
			sat_n = ovf_q | (quo_q > agcn_pkg::QUO_MAX);
			res_n = sat_n ? agcn_pkg::SAT_POS : q_lo;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			audio_out    <= res_n;
			envelope_now <= env_q;
			clipped      <= clip_q | sat_n;
		end
	end

	assign out_valid       = out_valid_q;
	assign sts.out_blocked = out_valid_q & out_stall;

endmodule

// ===== hw/rtl/agc_envelope_normalizer_unit.sv =====
// ----------------------------------------------------------------------------
// agc_envelope_normalizer_unit
// Each sample runs, in AM mode after the squares and the 16-step square root, the envelope
//   update and the 18-step restoring divider; in_stall holds off new samples until the output load.
// The next sample is accepted while a finished result waits in the output
//   register. Reset: registers to defaults, envelope to 33, output empty.
// ----------------------------------------------------------------------------
module agc_envelope_normalizer_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample beat
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [agcn_pkg::SAMPLE_W-1:0] sample_i,
	input  logic signed [agcn_pkg::SAMPLE_W-1:0] sample_q,
	// result beat
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [agcn_pkg::SAMPLE_W-1:0] audio_out,
	output logic [agcn_pkg::ENV_W-1:0]           envelope_now,
	output logic                                 clipped,
	// config port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [agcn_pkg::PADDR_W-1:0]         paddr,
	input  logic [agcn_pkg::APB_DW-1:0]          pwdata,
	output logic [agcn_pkg::APB_DW-1:0]          prdata,
	output logic                                 pready
);

	agcn_pkg::cfg_t cfg;
	agcn_pkg::cmd_t cmd;
	agcn_pkg::sts_t sts;

	agcn_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	agcn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.am_mode  (cfg.am_mode),
		.sts      (sts),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	agcn_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sample_i     (sample_i),
		.sample_q     (sample_q),
		.out_stall    (out_stall),
		.sts          (sts),
		.out_valid    (out_valid),
		.audio_out    (audio_out),
		.envelope_now (envelope_now),
		.clipped      (clipped)
	);

	// one sample in flight: an accepted beat closes the input
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a sample is in flight");

	// reported envelope never drops under the floor
	a_env_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (envelope_now != '0) && (envelope_now >= cfg.envelope_floor))
		else $error("envelope below floor");

	// outside AM mode a clip comes only from quotient saturation
	a_clip_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped && !cfg.am_mode |->
			(audio_out == agcn_pkg::SAT_POS) || (audio_out == agcn_pkg::SAT_NEG))
		else $error("clipped set on an unsaturated result");

endmodule
